// File: rtl/core/mlts_pkg.sv
// Shared types and constants for the multi-link timeout supervisor.
package mlts_pkg;

  localparam int ID_W        = 16;
  localparam int TIME_W      = 48;
  localparam int TMO_W       = 32;
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = 5;  // holds 0..MAX_RESULTS

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd20000;

  localparam logic CMD_MSG  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_RESTORED = 2'd0;
  localparam kind_t KIND_DOWN     = 2'd1;
  localparam kind_t KIND_DROP     = 2'd2;

  // one table entry
  typedef struct packed {
    logic              judged;
    logic              link_up;
    logic [TIME_W-1:0] last_seen;
    logic [ID_W-1:0]   source;
  } entry_t;

  // one result item
  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] src;
    logic            first;
  } res_t;

  typedef enum logic [0:0] {
    ALU_CMP     = 1'b0,
    ALU_ABSDIFF = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [TIME_W-1:0] diff;
    logic              lt;
    logic              eq;
  } alu_res_t;

endpackage

// File: rtl/core/mlts_table.sv
// Source table memory: one write port, one registered read port.
module mlts_table
  import mlts_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/mlts_alu.sv
// Shared subtract unit: compare, or absolute difference of two times.
module mlts_alu
  import mlts_pkg::*;
(
  input  alu_op_t           op,
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  output alu_res_t          res
);

  logic [TIME_W:0] d_ab;
  logic [TIME_W:0] d_ba;

  always_comb begin
    d_ab    = {1'b0, a} - {1'b0, b};
    d_ba    = {1'b0, b} - {1'b0, a};
    res.lt  = d_ab[TIME_W];
    res.eq  = (a == b);
    res.diff = '0;
    if (op == ALU_ABSDIFF) begin
      res.diff = d_ab[TIME_W] ? d_ba[TIME_W-1:0] : d_ab[TIME_W-1:0];
    end
  end

endmodule

// File: rtl/core/multi_link_timeout_supervisor_unit.sv
// Top level of the multi-link timeout supervisor: sequencer, table and shared unit.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  in_     | in  | tvalid/tready      | tdata: app_id, now_ms; tuser: cmd
//  out_    | out | tvalid/tready      | tdata: source_id, first_report; tuser:
//          |     |                    | kind; tlast: last
//  cfg_    | in  | wr_en              | wr_data: timeout_ms
//
// The idle state takes the item. A message item reads and compares entry by
// entry until it finds its id or the insertion point; an insert then reads and
// moves up each entry below the gap, then writes the new entry. A tick reads,
// differences and judges each used entry, pushes each reported change after
// the first, then flushes. The single read port sets this order of steps.
// Reset clears the fill count, the down count and the timeout (to 20000);
// the table needs no clearing pass, entries past the fill count are unused.
// Output stalls hold the sequencer in the drop, push and flush states.
module multi_link_timeout_supervisor_unit
  import mlts_pkg::*;
#(
  parameter int SOURCES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [15:0] app_id, [63:16] now_ms
  input  logic [0:0]  in_tuser,   // [0] cmd
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] source_id, [16] first_report, [23:17] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data // timeout_ms
);

  localparam int CW = $clog2(SOURCES + 1);
  localparam int AW = (SOURCES > 1) ? $clog2(SOURCES) : 1;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_M_RD   = 11'b000_0000_0010,  // message scan: read entry
    S_M_CMP  = 11'b000_0000_0100,  // message scan: compare id
    S_INS_RD = 11'b000_0000_1000,  // insert: read entry below gap
    S_INS_WR = 11'b000_0001_0000,  // insert: move it up one
    S_DROP   = 11'b000_0010_0000,
    S_T_RD   = 11'b000_0100_0000,  // tick: read entry
    S_T_DIF  = 11'b000_1000_0000,  // tick: time difference
    S_T_CMP  = 11'b001_0000_0000,  // tick: judge and update
    S_T_PUSH = 11'b010_0000_0000,  // tick: hand held result to output
    S_FLUSH  = 11'b100_0000_0000   // tick: last result out
  } state_t;

  state_t state_r, state_nxt;

  logic [ID_W-1:0]      id_r, id_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic [TMO_W-1:0]     timeout_r, timeout_nxt;
  logic [CW-1:0]        count_r, count_nxt;   // table kept sorted by id
  logic [CW-1:0]        idx_r, idx_nxt;       // scan index / insert point
  logic [CW-1:0]        sh_r, sh_nxt;         // insert shift index
  logic [CW-1:0]        down_r, down_nxt;     // judged entries that are down
  logic [RES_CNT_W-1:0] nres_r, nres_nxt;
  logic [TIME_W-1:0]    diff_r, diff_nxt;
  logic                 pend_v_r, pend_v_nxt;
  res_t                 pend_r, pend_nxt;     // held back until last is known
  res_t                 cand_r, cand_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_res_r, out_res_nxt;
  logic                 out_last_r, out_last_nxt;

  logic          tbl_wr_en;
  logic [AW-1:0] tbl_wr_addr;
  entry_t        tbl_wr_data;
  logic          tbl_rd_en;
  logic [AW-1:0] tbl_rd_addr;
  entry_t        tbl_rd_data;

  alu_op_t           alu_op;
  logic [TIME_W-1:0] alu_a;
  logic [TIME_W-1:0] alu_b;
  alu_res_t          alu_res;

  logic          out_free;
  logic          load_out;
  res_t          load_res;
  logic          load_last;
  logic [CW-1:0] sh_m1;
  logic          up;
  logic          change;
  logic          old_down;
  res_t          new_res;

  mlts_table #(
    .DEPTH (SOURCES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  mlts_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign sh_m1     = sh_r - CW'(1);

  always_comb begin
    state_nxt   = state_r;
    id_nxt      = id_r;
    now_nxt     = now_r;
    timeout_nxt = cfg_wr_en ? cfg_wr_data : timeout_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    sh_nxt      = sh_r;
    down_nxt    = down_r;
    nres_nxt    = nres_r;
    diff_nxt    = diff_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    cand_nxt    = cand_r;

    tbl_wr_en   = 1'b0;
    tbl_wr_addr = idx_r[AW-1:0];
    tbl_wr_data = tbl_rd_data;
    tbl_rd_en   = 1'b0;
    tbl_rd_addr = idx_r[AW-1:0];

    alu_op = ALU_CMP;
    alu_a  = {{(TIME_W-ID_W){1'b0}}, id_r};
    alu_b  = {{(TIME_W-ID_W){1'b0}}, tbl_rd_data.source};

    load_out  = 1'b0;
    load_res  = pend_r;
    load_last = 1'b0;

    up       = alu_res.lt || alu_res.eq;
    change   = 1'b0;
    old_down = tbl_rd_data.judged && !tbl_rd_data.link_up;
    new_res  = pend_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          id_nxt   = in_tdata[15:0];
          now_nxt  = in_tdata[63:16];
          idx_nxt  = '0;
          nres_nxt = '0;
          state_nxt = (in_tuser[0] == CMD_TICK) ? S_T_RD : S_M_RD;
        end
      end

      S_M_RD: begin
        if (idx_r == count_r) begin
          // not found, goes at the end
          if (count_r == CW'(SOURCES)) begin
            state_nxt = S_DROP;
          end else begin
            sh_nxt    = count_r;
            state_nxt = S_INS_RD;
          end
        end else begin
          tbl_rd_en = 1'b1;
          state_nxt = S_M_CMP;
        end
      end

      S_M_CMP: begin
        if (alu_res.eq) begin
          tbl_wr_en             = 1'b1;
          tbl_wr_data.last_seen = now_r;
          state_nxt             = S_IDLE;
        end else if (alu_res.lt) begin
          // first larger id found: insert point is idx
          if (count_r == CW'(SOURCES)) begin
            state_nxt = S_DROP;
          end else begin
            sh_nxt    = count_r;
            state_nxt = S_INS_RD;
          end
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_M_RD;
        end
      end

      S_INS_RD: begin
        if (sh_r == idx_r) begin
          tbl_wr_en   = 1'b1;
          tbl_wr_data = '{judged: 1'b0, link_up: 1'b0, last_seen: now_r, source: id_r};
          count_nxt   = count_r + CW'(1);
          state_nxt   = S_IDLE;
        end else begin
          tbl_rd_en   = 1'b1;
          tbl_rd_addr = sh_m1[AW-1:0];
          state_nxt   = S_INS_WR;
        end
      end

      S_INS_WR: begin
        tbl_wr_en   = 1'b1;
        tbl_wr_addr = sh_r[AW-1:0];
        sh_nxt      = sh_m1;
        state_nxt   = S_INS_RD;
      end

      S_DROP: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_res  = '{kind: KIND_DROP, src: id_r, first: 1'b0};
          load_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_T_RD: begin
        if (idx_r == count_r) begin
          state_nxt = S_FLUSH;
        end else begin
          tbl_rd_en = 1'b1;
          state_nxt = S_T_DIF;
        end
      end

      S_T_DIF: begin
        alu_op    = ALU_ABSDIFF;
        alu_a     = now_r;
        alu_b     = tbl_rd_data.last_seen;
        diff_nxt  = alu_res.diff;
        state_nxt = S_T_CMP;
      end

      S_T_CMP: begin
        alu_a     = diff_r;
        alu_b     = {{(TIME_W-TMO_W){1'b0}}, timeout_r};
        change    = !tbl_rd_data.judged || (tbl_rd_data.link_up != up);
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_T_RD;
        if (change) begin
          tbl_wr_en           = 1'b1;
          tbl_wr_data.judged  = 1'b1;
          tbl_wr_data.link_up = up;
          // AND of stored states, as a count of downs
          down_nxt = down_r - CW'(old_down) + CW'(!up);
          new_res  = '{kind:  (down_nxt != '0) ? KIND_DOWN : KIND_RESTORED,
                       src:   tbl_rd_data.source,
                       first: !tbl_rd_data.judged};
          if (nres_r < RES_CNT_W'(MAX_RESULTS)) begin
            nres_nxt = nres_r + RES_CNT_W'(1);
            if (pend_v_r) begin
              cand_nxt  = new_res;
              state_nxt = S_T_PUSH;
            end else begin
              pend_nxt   = new_res;
              pend_v_nxt = 1'b1;
            end
          end
        end
      end

      S_T_PUSH: begin
        if (out_free) begin
          load_out  = 1'b1;
          pend_nxt  = cand_r;
          state_nxt = S_T_RD;
        end
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          load_out   = 1'b1;
          load_last  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // output register
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = load_res;
      out_last_nxt  = load_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      timeout_r   <= TIMEOUT_RESET;
      count_r     <= '0;
      down_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      timeout_r   <= timeout_nxt;
      count_r     <= count_nxt;
      down_r      <= down_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    now_r      <= now_nxt;
    idx_r      <= idx_nxt;
    sh_r       <= sh_nxt;
    nres_r     <= nres_nxt;
    diff_r     <= diff_nxt;
    pend_r     <= pend_nxt;
    cand_r     <= cand_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_res_r.first, out_res_r.src};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/core/mlts_checker.sv
// Port-level checks for the supervisor, bound to the top level.
module mlts_checker
  import mlts_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // reset leaves the block ready with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("not idle after reset");

  // an accepted item leaves the block not ready in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after an accepted item");

  // a drop is always the single, non-first result of its item
  a_drop_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_DROP) |-> out_tlast && !out_tdata[16])
    else $error("malformed drop result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

endmodule

bind multi_link_timeout_supervisor_unit mlts_checker u_mlts_checker (.*);

// File: verif/tb_multi_link_timeout_supervisor_unit.sv
// Testbench for the multi-link timeout supervisor: directed and random items, self-checking.
`timescale 1ns / 1ps

module tb_multi_link_timeout_supervisor_unit;
  import mlts_pkg::*;

  localparam int      SOURCES      = 16;
  // Longest quiet stretch the block may need after its last result: an insert
  // scans and then shifts the table, a tick visits every used entry.
  localparam int      DRAIN_CYCLES = 128;
  localparam int      LONG_HOLD    = 400;
  // Watchdog limit on the whole run, with a wide margin.
  localparam longint  CYCLE_LIMIT  = 400000;

  // one expected result item
  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] source_id;
    logic            first_report;
    logic            last;
  } report_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_tvalid    = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata     = '0;   // [15:0] app_id, [63:16] now_ms
  logic [0:0]  in_tuser     = '0;   // [0] cmd
  logic        out_tvalid;
  logic        out_tready   = 1'b0;
  logic [23:0] out_tdata;           // [15:0] source_id, [16] first_report
  logic [1:0]  out_tuser;           // [1:0] kind
  logic        out_tlast;
  logic        cfg_wr_en    = 1'b0;
  logic [31:0] cfg_wr_data  = '0;   // timeout_ms

  // Shadow copy of the supervision table and the timeout register
  bit                tbl_used   [SOURCES];
  logic [ID_W-1:0]   tbl_id     [SOURCES];
  logic [TIME_W-1:0] tbl_stamp  [SOURCES];
  bit                tbl_judged [SOURCES];
  bit                tbl_up     [SOURCES];
  logic [TMO_W-1:0]  cur_timeout = TIMEOUT_RESET;

  report_t report_q[$];   // results still owed by the block, oldest first

  int     err_count   = 0;
  longint cycle_count = 0;

  // Sender / receiver idling controls
  bit          tx_idle_en   = 1'b1;
  logic        rx_idle_en   = 1'b1;
  int          hold_req_cnt = 0;   // bumped by the stimulus to ask for a long hold
  int          hold_ack_cnt = 0;
  int          hold_left    = 0;
  int          stall_left   = 0;

  // Time window for random items of the current phase
  logic [TIME_W-1:0] phase_base = '0;
  logic [63:0]       phase_span = 64'd2;

  multi_link_timeout_supervisor_unit #(
    .SOURCES(SOURCES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_multi_link_timeout_supervisor_unit: FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Predictor: updates the shadow table for one accepted item and queues the
  // result items it owes.
  // ------------------------------------------------------------------------
  function automatic void predict_item(logic cmd, logic [ID_W-1:0] id,
                                       logic [TIME_W-1:0] now);
    int                free_slot;
    int                pick;
    int                n;
    bit                seen [SOURCES];
    logic [TIME_W-1:0] diff;
    bit                up;
    bit                all_up;
    bit                hit;
    report_t           r;

    free_slot = -1;
    n         = 0;
    hit       = 1'b0;
    if (cmd == CMD_MSG) begin
      // known id: restamp only; scan stops at the match
      for (int i = 0; i < SOURCES; i++) begin
        if (!hit && tbl_used[i] && tbl_id[i] == id) begin
          tbl_stamp[i] = now;
          hit          = 1'b1;
        end
        if (!hit && !tbl_used[i] && free_slot < 0) free_slot = i;
      end
      if (hit) return;
      if (free_slot < 0) begin
        // table full: the message is dropped and reported
        r = '{kind: KIND_DROP, source_id: id, first_report: 1'b0, last: 1'b1};
        report_q.insert(report_q.size(), r);
        return;
      end
      tbl_used[free_slot]   = 1'b1;
      tbl_id[free_slot]     = id;
      tbl_stamp[free_slot]  = now;
      tbl_judged[free_slot] = 1'b0;
      tbl_up[free_slot]     = 1'b0;
    end else begin
      foreach (seen[i]) seen[i] = 1'b0;
      for (int step = 0; step < SOURCES; step++) begin
        // next unvisited entry in ascending id order
        pick = -1;
        for (int i = 0; i < SOURCES; i++) begin
          if (tbl_used[i] && !seen[i] && (pick < 0 || tbl_id[i] < tbl_id[pick])) pick = i;
        end
        if (pick < 0) break;
        seen[pick] = 1'b1;
        diff = (now > tbl_stamp[pick]) ? now - tbl_stamp[pick] : tbl_stamp[pick] - now;
        up   = (diff <= {16'd0, cur_timeout});
        if (!tbl_judged[pick] || tbl_up[pick] != up) begin
          r.first_report   = !tbl_judged[pick];
          tbl_judged[pick] = 1'b1;
          tbl_up[pick]     = up;
          // AND over stored states; unvisited entries keep their old state
          all_up = 1'b1;
          for (int i = 0; i < SOURCES; i++) begin
            if (tbl_used[i] && tbl_judged[i] && !tbl_up[i]) all_up = 1'b0;
          end
          if (n < MAX_RESULTS) begin
            r.kind      = all_up ? KIND_RESTORED : KIND_DOWN;
            r.source_id = tbl_id[pick];
            r.last      = 1'b0;
            report_q.insert(report_q.size(), r);
            n++;
          end
        end
      end
      if (n > 0) report_q[report_q.size() - 1].last = 1'b1;
    end
  endfunction

  // ------------------------------------------------------------------------
  // Result checker and receiver backpressure. Samples at the clock edge, so
  // only pre-edge values are seen; out_tready gets one NBA per edge.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (report_q.size() == 0) begin
        $error("unexpected result: kind %0d source_id 0x%h", out_tuser, out_tdata[15:0]);
        err_count++;
      end else begin
        want = report_q.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", want.kind, out_tuser);
          err_count++;
        end
        if (out_tdata[15:0] !== want.source_id) begin
          $error("source_id mismatch: expected 0x%h, actual 0x%h",
                 want.source_id, out_tdata[15:0]);
          err_count++;
        end
        if (out_tdata[16] !== want.first_report) begin
          $error("first_report mismatch: expected %0d, actual %0d",
                 want.first_report, out_tdata[16]);
          err_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_tlast);
          err_count++;
        end
      end
    end
    // long hold on request, else short random stall bursts
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt = hold_req_cnt;
      hold_left    = LONG_HOLD - 1;
      out_tready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Offer one item, optionally after a short idle burst; returns at the edge
  // where it was accepted. tvalid stays up for a back-to-back follower.
  task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] now);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {now, id};
    do @(posedge clk); while (!in_tready);
    predict_item(cmd, id, now);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
  endtask

  // Timeout writes only with the block idle: all results out, plus room for
  // an insert that produces nothing to finish.
  task automatic apply_timeout(input logic [TMO_W-1:0] value);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_timeout  = value;
  endtask

  function automatic bit id_in_table(logic [ID_W-1:0] id);
    for (int i = 0; i < SOURCES; i++) begin
      if (tbl_used[i] && tbl_id[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [ID_W-1:0] fresh_id();
    logic [ID_W-1:0] id;
    do id = ID_W'($urandom); while (id_in_table(id));
    return id;
  endfunction

  function automatic logic [ID_W-1:0] pick_known_id();
    int k;
    if (!tbl_used[0]) return ID_W'($urandom);  // slots fill from 0 upward
    do k = $urandom_range(0, SOURCES - 1); while (!tbl_used[k]);
    return tbl_id[k];
  endfunction

  // One random item in the phase's time window; now and then a time anywhere
  // in the 48-bit range so that large timeouts still see links go down.
  task automatic random_item();
    logic [63:0]       r;
    logic [TIME_W-1:0] now;
    int                roll;
    r    = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 15) == 0) now = r[TIME_W-1:0];
    else now = phase_base + TIME_W'(r % (phase_span + 64'd1));
    if (roll < 42)      send_item(CMD_MSG, pick_known_id(), now);
    else if (roll < 52) send_item(CMD_MSG, fresh_id(), now);
    else                send_item(CMD_TICK, ID_W'($urandom), now);
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Reset timeout of 20000: a difference of exactly the timeout is still up,
  // one more is down, and time running backwards counts the same way.
  task automatic test_reset_timeout();
    send_item(CMD_MSG,  16'h0000, 48'd1000);
    send_item(CMD_TICK, 16'h0000, 48'd21000);
    send_item(CMD_TICK, 16'hFFFF, 48'd21001);
    send_item(CMD_TICK, ID_W'($urandom), 48'd0);
    send_item(CMD_TICK, ID_W'($urandom), 48'd500);  // no change, no result
  endtask

  // Timeout and time extremes
  task automatic test_extremes();
    apply_timeout(32'd0);
    send_item(CMD_MSG,  16'hFFFF, 48'hFFFF_FFFF_FFFF);
    send_item(CMD_TICK, 16'h5A5A, 48'hFFFF_FFFF_FFFF);
    apply_timeout(32'hFFFF_FFFF);
    send_item(CMD_TICK, 16'hA5A5, 48'h0000_8000_0000);
    send_item(CMD_TICK, 16'h0000, 48'h0000_8000_0000);
  endtask

  // Fill the table in random id order, judge all sixteen in one tick, then a
  // drop for an unknown id and a restamp of a known one while full.
  task automatic test_table_full();
    logic [63:0]       r;
    logic [TIME_W-1:0] base;
    apply_timeout(32'd50);
    r    = {$urandom, $urandom};
    base = r[TIME_W-1:0];
    while (!tbl_used[SOURCES - 1]) begin
      send_item(CMD_MSG, fresh_id(), base + TIME_W'($urandom_range(0, 100)));
    end
    send_item(CMD_TICK, ID_W'($urandom), base + 48'd50);
    send_item(CMD_MSG,  fresh_id(),      base);
    send_item(CMD_MSG,  pick_known_id(), base + 48'd1000);
    send_item(CMD_TICK, ID_W'($urandom), base + 48'd1000);
  endtask

  task automatic test_random_traffic(input logic [TMO_W-1:0] tmo, input int count);
    logic [63:0] r;
    apply_timeout(tmo);
    r          = {$urandom, $urandom};
    phase_base = r[TIME_W-1:0];
    phase_span = 2 * {32'd0, tmo} + 64'd2;
    repeat (count) random_item();
  endtask

  // Receiver holds off for a long stretch while every entry flips on each
  // tick, so the block's output fills and it stops taking input.
  task automatic test_backpressure();
    logic [63:0]       r;
    logic [TIME_W-1:0] ts;
    apply_timeout(32'd1000);
    r  = {$urandom, $urandom};
    ts = r[TIME_W-1:0];
    hold_req_cnt <= hold_req_cnt + 1;
    for (int i = 0; i < SOURCES; i++) send_item(CMD_MSG, tbl_id[i], ts);
    for (int k = 0; k < 10; k++) begin
      send_item(CMD_TICK, ID_W'($urandom), (k % 2 == 0) ? ts + 48'd2000 : ts);
    end
  endtask

  // Sender stops until every owed result is out, then carries on.
  task automatic test_drain_pause();
    repeat (20) random_item();
    drain_results();
    repeat (20) random_item();
  endtask

  // Last stretch: no idling on either side
  task automatic test_steady_stream();
    tx_idle_en  = 1'b0;
    rx_idle_en <= 1'b0;
    test_random_traffic($urandom_range(1, 200000), 36);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_timeout();
    test_extremes();
    test_table_full();
    test_random_traffic($urandom_range(1, 100000), 30);
    test_random_traffic(32'd0, 30);
    test_random_traffic(32'd1, 30);
    test_random_traffic(32'hFFFF_FFFF, 30);
    test_random_traffic($urandom, 30);
    test_backpressure();
    test_drain_pause();
    test_steady_stream();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_multi_link_timeout_supervisor_unit: PASS");
    end else begin
      $display("tb_multi_link_timeout_supervisor_unit: FAIL");
    end
    $finish;
  end

endmodule
